>>> rtl/sliding_window_histogram_density_score_unit_defines.svh
// assertion macros for the density score unit
`ifndef SLIDING_WINDOW_HISTOGRAM_DENSITY_SCORE_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_HISTOGRAM_DENSITY_SCORE_UNIT_DEFINES_SVH

// implication checked on every clock, off during reset
`define SWH_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication
`define SWH_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> rtl/swhds_pkg.sv
// ---------------------------------------------------------------------------
// swhds_pkg
// shared constants for the sliding window histogram density score unit
// ---------------------------------------------------------------------------
`default_nettype none
package swhds_pkg;
    localparam int CNT_W = 9;
    localparam logic [8:0] COUNT_MAX = 9'd511;
    localparam logic signed [15:0] FLOOR_Q10 = -16'sd23578;
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic signed [21:0] SUM_MAX = 22'sd2097151;
    localparam logic signed [21:0] SUM_MIN = -22'sd2097152;
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD = 1'b1;
    localparam logic [0:0] REG_PROJ = 1'b0;
    localparam logic [0:0] REG_SLOTS = 1'b1;

    // ln(n) in Q10 for n in 1..511, table built at elaboration
    function automatic logic [12:0] ln_calc(input int n);
        int e;
        longint unsigned x;
        longint unsigned l2;
        int frac;
        e = 0;
        frac = 0;
        if (n == 0)
            return 13'd0;
        while ((n >> (e + 1)) != 0)
            e++;
        x = (longint'(n) << 16) >> e;
        for (int i = 1; i <= 16; i++)
        begin
            x = (x * x) >> 16;
            if (x >= (64'd2 << 16))
            begin
                x = x >> 1;
                frac = frac | (1 << (16 - i));
            end
        end
        l2 = (longint'(e) << 16) | longint'(frac);
        return 13'((l2 * 45426 + (64'd1 << 21)) >> 22);
    endfunction

    typedef logic [12:0] ln_tab_t [512];

    function automatic ln_tab_t ln_build();
        ln_tab_t t;
        for (int k = 0; k < 512; k++)
            t[k] = ln_calc(k);
        return t;
    endfunction

    localparam ln_tab_t LN_TAB = ln_build();
endpackage
`default_nettype wire

>>> rtl/swhds_divider.sv
// ---------------------------------------------------------------------------
// swhds_divider
// restoring signed divide of the 22-bit sum by the projection count
// ---------------------------------------------------------------------------
`default_nettype none
module swhds_divider
    import swhds_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [21:0] dividend,
    input  wire logic [8:0]         divisor,
    output logic                    done,
    output logic signed [15:0]      quotient
);
    logic [21:0] rem_reg, rem_next;
    logic [21:0] quo_reg, quo_next;
    logic [8:0]  dvs_reg;
    logic        neg_reg;
    logic [4:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [22:0] trial;
    logic [21:0] shifted;
    logic signed [22:0] sq;

    // one quotient bit a cycle
    always_comb
    begin
        shifted   = {rem_reg[20:0], quo_reg[21]};
        trial     = {1'b0, shifted} - {14'd0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (!trial[22])
                rem_next = trial[21:0];
            else
                rem_next = shifted;
            quo_next  = {quo_reg[20:0], !trial[22]};
            step_next = step_reg - 5'd1;
            if (step_reg == 5'd0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            step_reg <= 5'd0;
        end
        else
        begin
            done     <= busy_reg && (step_reg == 5'd0);
            busy_reg <= start ? 1'b1 : busy_next;
            step_reg <= start ? 5'd21 : step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 22'd0;
            quo_reg <= dividend[21] ? 22'(-dividend) : dividend;
            dvs_reg <= divisor;
            neg_reg <= dividend[21];
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // sign and saturate
    always_comb
    begin
        sq = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        if (sq > 23'sd32767)
            quotient = 16'sd32767;
        else if (sq < -23'sd32768)
            quotient = -16'sd32768;
        else
            quotient = sq[15:0];
    end
endmodule
`default_nettype wire

>>> rtl/sliding_window_histogram_density_score_unit.sv
// ---------------------------------------------------------------------------
// sliding_window_histogram_density_score_unit
// sliding-window histograms per projection, mean log density score per sample
// ---------------------------------------------------------------------------
// channel  direction  fields
// in       sink       command bin_index proj_select log_step
// out      source     score
// cfg      sink       cfg_we cfg_index cfg_data
//
// a sample element steps through accept, window and count/total read, term add,
// count write, evicted count read and evicted count write; the evicted count
// read is skipped while its window slot is still empty, and the single histogram
// memory port sets this order. a log step load is taken straight from idle. the
// last element adds the serial divide and the result load, which waits while the
// previous score stalls. after reset a clearing pass runs over all memories.
// ---------------------------------------------------------------------------
`default_nettype none
module sliding_window_histogram_density_score_unit
    import swhds_pkg::*;
#(
    parameter int MAX_PROJ = 64,
    parameter int BINS = 64,
    parameter int WINDOW_DEPTH = 256
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               command,
    input  wire logic [5:0]         bin_index,
    input  wire logic [5:0]         proj_select,
    input  wire logic signed [15:0] log_step,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      score,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [8:0]         cfg_data
);
    localparam int PW = (MAX_PROJ > 1) ? $clog2(MAX_PROJ) : 1;
    localparam int BW = $clog2(BINS);
    localparam int WW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int HD = MAX_PROJ * BINS;
    localparam int WD = MAX_PROJ * WINDOW_DEPTH;
    localparam int HA = $clog2(HD);
    localparam int WA = (WD > 1) ? $clog2(WD) : 1;
    localparam int CD = (BINS > WINDOW_DEPTH) ? BINS : WINDOW_DEPTH;
    localparam int CA = $clog2(MAX_PROJ * CD + 1);

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RW = 4'd2, S_RC = 4'd3,
        S_WC = 4'd4, S_RO = 4'd5, S_WO = 4'd6, S_DIV = 4'd7, S_OUT = 4'd8;

    // memories
    logic [CNT_W:0] hist_mem [HD];      // {unused, count}
    logic [BW:0]    win_mem  [WD];      // {valid, bin}
    logic [8:0]     tot_mem  [MAX_PROJ];
    logic signed [15:0] step_mem [MAX_PROJ];

    logic [3:0]  state_reg;
    logic [CA-1:0] clr_reg;
    logic [6:0]  pc_reg;
    logic [8:0]  ws_reg;
    logic [PW-1:0] proj_reg;
    logic [WW-1:0] ptr_reg;
    logic signed [21:0] sum_reg;
    logic [BW-1:0] bin_reg;
    logic [BW:0]   old_reg;
    logic [8:0]  tot_reg;
    logic signed [15:0] step_reg;
    logic signed [15:0] score_reg;
    logic          out_reg;

    logic [HA-1:0] h_addr;
    logic          h_we;
    logic [CNT_W:0] h_wd, h_rd;
    logic [BW:0]    w_rd;
    logic [WA-1:0]  w_addr;
    logic [8:0] np, ns;
    logic [BW-1:0] bin_c;
    logic signed [21:0] term, sum_ext;
    logic signed [22:0] sum_w;
    logic div_start, div_done;
    logic signed [15:0] div_q;
    logic out_load;

    assign np = (pc_reg == 7'd0) ? 9'd1 :
                ({2'd0, pc_reg} > 9'(MAX_PROJ)) ? 9'(MAX_PROJ) : {2'd0, pc_reg};
    assign ns = (ws_reg == 9'd0) ? 9'd1 :
                ({1'b0, ws_reg} > 10'(WINDOW_DEPTH)) ? 9'(WINDOW_DEPTH) : ws_reg;
    assign bin_c = ({26'd0, bin_index} >= 32'(BINS)) ? BW'(BINS - 1) : BW'(bin_index);
    assign w_addr = WA'({proj_reg, ptr_reg});

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_reg;
    assign score = score_reg;

    // result register loads once the previous beat is gone
    assign out_load = (state_reg == S_OUT) && (!out_reg || !out_stall);

    // histogram address select per step
    always_comb
    begin
        h_addr = HA'({proj_reg, bin_reg});
        h_we = 1'b0;
        h_wd = h_rd;
        case (state_reg)
            S_CLR:
            begin
                h_addr = clr_reg[HA-1:0];
                h_we = ({{(32-CA){1'b0}}, clr_reg} < HD);
                h_wd = '0;
            end
            S_RW: h_addr = HA'({proj_reg, bin_reg});
            S_WC:
            begin
                h_we = (h_rd[8:0] != COUNT_MAX);
                h_wd = {1'b0, h_rd[8:0] + 9'd1};
            end
            S_RO:
            begin
                h_we = 1'b0;
                h_addr = HA'({proj_reg, old_reg[BW-1:0]});
            end
            S_WO:
            begin
                h_addr = HA'({proj_reg, old_reg[BW-1:0]});
                h_we = old_reg[BW] && (h_rd[8:0] != 9'd0);
                h_wd = {1'b0, h_rd[8:0] - 9'd1};
            end
            default: h_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            hist_mem[h_addr] <= h_wd;
        h_rd <= hist_mem[h_addr];
    end

    // window slot read and rewrite
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR && {{(32-CA){1'b0}}, clr_reg} < WD)
            win_mem[clr_reg[WA-1:0]] <= '0;
        else if (state_reg == S_RC)
            win_mem[w_addr] <= {1'b1, bin_reg};
        w_rd <= win_mem[w_addr];
    end

    // term for the element from count and total before the update
    always_comb
    begin
        if (h_rd[8:0] == 9'd0 || tot_reg == 9'd0)
            term = 22'(FLOOR_Q10);
        else
            term = $signed({9'd0, LN_TAB[h_rd[8:0]]}) - $signed({9'd0, LN_TAB[tot_reg]})
                   - 22'(step_reg);
        sum_w = 23'(sum_reg) + 23'(term);
        if (sum_w > 23'(SUM_MAX))
            sum_ext = SUM_MAX;
        else if (sum_w < 23'(SUM_MIN))
            sum_ext = SUM_MIN;
        else
            sum_ext = sum_w[21:0];
    end

    function automatic logic [6:0] pc_last();
        return ({{(9-PW){1'b0}}, proj_reg} + 9'd1 >= np) ? 7'd1 : 7'd0;
    endfunction

    assign div_start = (state_reg == S_WO) && ({2'd0, pc_last()} != 9'd0);

    swhds_divider u_div
    (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_reg),
        .divisor(np), .done(div_done), .quotient(div_q)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            pc_reg <= 7'd64;
            ws_reg <= 9'd256;
            proj_reg <= '0;
            ptr_reg <= '0;
            sum_reg <= '0;
            out_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_PROJ)
                pc_reg <= cfg_data[6:0];
            if (cfg_we && cfg_index == REG_SLOTS)
                ws_reg <= cfg_data;
            if (out_load)
                out_reg <= 1'b1;
            else if (out_reg && !out_stall)
                out_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + CA'(1);
                    if ({{(32-CA){1'b0}}, clr_reg} == MAX_PROJ * CD - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (in_valid && !in_stall && command == CMD_SAMPLE)
                        state_reg <= S_RW;
                S_RW: state_reg <= S_RC;
                S_RC:
                begin
                    sum_reg <= sum_ext;
                    state_reg <= S_WC;
                end
                S_WC: state_reg <= old_reg[BW] ? S_RO : S_WO;
                S_RO: state_reg <= S_WO;
                S_WO:
                begin
                    if (pc_last() != 7'd0)
                        state_reg <= S_DIV;
                    else
                    begin
                        proj_reg <= proj_reg + PW'(1);
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV:
                    if (div_done)
                        state_reg <= S_OUT;
                S_OUT:
                    if (out_load)
                    begin
                        sum_reg <= '0;
                        proj_reg <= '0;
                        ptr_reg <= ({23'd0, ptr_reg} + 32'd1 >= {23'd0, ns}) ?
                                   '0 : ptr_reg + WW'(1);
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload and totals
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR && {{(32-CA){1'b0}}, clr_reg} < MAX_PROJ)
        begin
            tot_mem[clr_reg[PW-1:0]] <= 9'd0;
            step_mem[clr_reg[PW-1:0]] <= 16'sd0;
        end
        else if (in_valid && !in_stall && command == CMD_LOAD)
        begin
            if ({26'd0, proj_select} < MAX_PROJ)
                step_mem[PW'(proj_select)] <= log_step;
        end
        if (in_valid && !in_stall)
            bin_reg <= bin_c;
        if (state_reg == S_RW)
        begin
            tot_reg <= tot_mem[proj_reg];
            step_reg <= step_mem[proj_reg];
        end
        if (state_reg == S_RC)
            old_reg <= w_rd;
        if (state_reg == S_WC)
            tot_mem[proj_reg] <= ((tot_reg != COUNT_MAX) ? tot_reg + 9'd1 : tot_reg)
                - (old_reg[BW] ? 9'd1 : 9'd0);
        if (out_load)
            score_reg <= div_q;
    end
endmodule
`default_nettype wire

>>> rtl/swhds_checker.sv
// ---------------------------------------------------------------------------
// swhds_checker
// port-level checks bound to the density score unit
// ---------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_histogram_density_score_unit_defines.svh"
module swhds_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic [15:0] score
);
    // handshake outputs always known out of reset
    `SWH_ASSERT_IMP(a_known, clk, rst_n, 1'b1, !$isunknown({in_stall, out_valid}))
    // stalled result keeps its value
    `SWH_ASSERT_NXT(a_score_hold, clk, rst_n, out_valid && out_stall, $stable(score))
    // stalled result stays valid
    `SWH_ASSERT_NXT(a_valid_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule

bind sliding_window_histogram_density_score_unit swhds_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .score(score)
);
`default_nettype wire
